### sv/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the delivery rate sampler.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int TimeW = 48;
  localparam int CntW  = 64;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_SENT  = 2'd0,
    OP_ACKED = 2'd1,
    OP_GEN   = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TimeW-1:0]   now;
    logic [31:0]        bytes_in_flight;
    logic               cwnd_room;
    logic               nothing_pending;
    logic [TimeW-1:0]   min_rtt;
    logic [15:0]        packet_size;
    logic               pkt_acked_already;
    logic [CntW-1:0]    pkt_delivered;
    logic [TimeW-1:0]   pkt_delivered_time;
    logic [TimeW-1:0]   pkt_first_sent_time;
    logic [TimeW-1:0]   pkt_sent_time;
    logic               pkt_app_limited;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_OUT  = 2'd2
  } st_t;

endpackage

### sv/drs_front.sv
// ----------------------------------------------------------------------------
// drs_front
// Accepts operations, pre-classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module drs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [47:0]          in_now,
  input  logic [31:0]          in_bytes_in_flight,
  input  logic [31:0]          in_cwnd,
  input  logic                 in_nothing_pending,
  input  logic [47:0]          in_min_rtt,
  input  logic [15:0]          in_packet_size,
  input  logic [63:0]          in_pkt_delivered,
  input  logic [47:0]          in_pkt_delivered_time,
  input  logic [47:0]          in_pkt_first_sent_time,
  input  logic [47:0]          in_pkt_sent_time,
  input  logic                 in_pkt_app_limited,
  output logic                 q_valid,
  input  logic                 q_ready,
  output drs_pkg::cmd_t        q_cmd
);
  import drs_pkg::*;

  cmd_t       mem_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    cmd.op                  = op_t'(in_op);
    cmd.now                 = in_now;
    cmd.bytes_in_flight     = in_bytes_in_flight;
    cmd.cwnd_room           = in_bytes_in_flight < in_cwnd;
    cmd.nothing_pending     = in_nothing_pending;
    cmd.min_rtt             = in_min_rtt;
    cmd.packet_size         = in_packet_size;
    cmd.pkt_acked_already   = in_pkt_delivered_time == '0;
    cmd.pkt_delivered       = in_pkt_delivered;
    cmd.pkt_delivered_time  = in_pkt_delivered_time;
    cmd.pkt_first_sent_time = in_pkt_first_sent_time;
    cmd.pkt_sent_time       = in_pkt_sent_time;
    cmd.pkt_app_limited     = in_pkt_app_limited;
  end

  assign in_ready = cnt_r != 2'(QDepth);
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue count overflow");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'(QDepth)) |-> wp_r == rp_r)
    else $error("queue pointers out of step");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QDepth) |-> !in_ready) else $error("push into full queue");

endmodule

### sv/drs_div.sv
// ----------------------------------------------------------------------------
// drs_div
// Radix-2 restoring divider, 64-bit dividend by 48-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module drs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);
  import drs_pkg::*;

  logic [63:0] q_r;
  logic [48:0] rem_r;
  logic [47:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [48:0] trial;
  logic [48:0] shifted;

  assign shifted  = {rem_r[47:0], q_r[63]};
  assign trial    = shifted - {1'b0, d_r};
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (!trial[48]) begin
        rem_r <= trial;
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(CntW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done longer than one cycle");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without work");

endmodule

### sv/drs_back.sv
// ----------------------------------------------------------------------------
// drs_back
// Sampler state and operation execution; generate runs the serial divider.
// ----------------------------------------------------------------------------
module drs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  drs_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_sample_valid,
  output logic [63:0]   out_sample_delivered,
  output logic [47:0]   out_sample_interval,
  output logic [63:0]   out_last_rate,
  output logic          out_sample_app_limited,
  output logic [63:0]   out_total_delivered,
  output logic [63:0]   out_snap_delivered,
  output logic [47:0]   out_snap_delivered_time,
  output logic [47:0]   out_snap_first_sent_time,
  output logic          out_snap_app_limited
);
  import drs_pkg::*;

  st_t         st_r, st_nxt;
  logic [63:0] dlv_r, al_mark_r, new_dlv_r, rate_r;
  logic [47:0] dstamp_r, fsent_r, new_stamp_r, sspan_r, aspan_r;
  logic        new_al_r;

  logic        ov_r;
  logic        o_sv_r, o_sal_r, o_snal_r;
  logic [63:0] o_sd_r, o_td_r, o_snd_r;
  logic [47:0] o_si_r, o_sndt_r, o_snft_r;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_q;
  logic [47:0] iv;
  logic [63:0] dl;
  logic [63:0] mark_sum;
  logic        take, out_free;

  assign iv       = (aspan_r > sspan_r) ? aspan_r : sspan_r;
  assign dl       = dlv_r - new_dlv_r;
  assign mark_sum = dlv_r + 64'(q_cmd.bytes_in_flight);
  assign out_free = !ov_r || out_ready;
  assign q_ready  = st_r == ST_IDLE && out_free;
  assign take     = q_valid && q_ready;

  drs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dl),
    .divisor  (iv),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (take && q_cmd.op == OP_GEN && new_stamp_r != '0 &&
            iv >= q_cmd.min_rtt && iv != '0) begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ov_r        <= 1'b0;
      dlv_r       <= '0;
      dstamp_r    <= '0;
      fsent_r     <= '0;
      al_mark_r   <= '0;
      new_dlv_r   <= '0;
      new_stamp_r <= '0;
      new_al_r    <= 1'b0;
      sspan_r     <= '0;
      aspan_r     <= '0;
      rate_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (div_done) rate_r <= div_q;
      if (st_r == ST_OUT && out_free) begin
        ov_r   <= 1'b1;
        o_sd_r <= dl;
        o_si_r <= iv;
        o_sv_r <= 1'b1;
        o_td_r <= dlv_r;
        o_sal_r <= new_al_r;
      end
      if (take) begin
        o_sv_r   <= 1'b0;
        o_sd_r   <= '0;
        o_si_r   <= '0;
        o_snd_r  <= '0;
        o_sndt_r <= '0;
        o_snft_r <= '0;
        o_snal_r <= 1'b0;
        o_sal_r  <= new_al_r;
        o_td_r   <= dlv_r;
        ov_r     <= !div_start;
        case (q_cmd.op)
          OP_SENT: begin
            o_snd_r  <= dlv_r;
            o_snal_r <= al_mark_r != '0;
            if (q_cmd.bytes_in_flight == '0) begin
              dstamp_r <= q_cmd.now;
              fsent_r  <= q_cmd.now;
              o_sndt_r <= q_cmd.now;
              o_snft_r <= q_cmd.now;
            end else begin
              o_sndt_r <= dstamp_r;
              o_snft_r <= fsent_r;
            end
          end
          OP_ACKED: begin
            if (!q_cmd.pkt_acked_already) begin
              dlv_r    <= dlv_r + 64'(q_cmd.packet_size);
              o_td_r   <= dlv_r + 64'(q_cmd.packet_size);
              dstamp_r <= q_cmd.now;
              if (q_cmd.pkt_delivered > new_dlv_r) begin
                new_dlv_r   <= q_cmd.pkt_delivered;
                new_stamp_r <= q_cmd.pkt_delivered_time;
                new_al_r    <= q_cmd.pkt_app_limited;
                o_sal_r     <= q_cmd.pkt_app_limited;
                sspan_r     <= q_cmd.pkt_sent_time - q_cmd.pkt_first_sent_time;
                aspan_r     <= q_cmd.now - q_cmd.pkt_delivered_time;
                fsent_r     <= q_cmd.pkt_sent_time;
              end
            end
          end
          OP_GEN: begin
            if (al_mark_r != '0 && dlv_r > al_mark_r) al_mark_r <= '0;
            if (new_stamp_r != '0) begin
              o_sd_r <= dl;
              if (iv >= q_cmd.min_rtt) begin
                o_sv_r <= 1'b1;
                o_si_r <= iv;
              end
            end
          end
          OP_CHECK: begin
            if (q_cmd.cwnd_room && q_cmd.nothing_pending) begin
              al_mark_r <= (mark_sum != '0) ? mark_sum : 64'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid                = ov_r;
  assign out_sample_valid         = o_sv_r;
  assign out_sample_delivered     = o_sd_r;
  assign out_sample_interval      = o_si_r;
  assign out_last_rate            = rate_r;
  assign out_sample_app_limited   = o_sal_r;
  assign out_total_delivered      = o_td_r;
  assign out_snap_delivered       = o_snd_r;
  assign out_snap_delivered_time  = o_sndt_r;
  assign out_snap_first_sent_time = o_snft_r;
  assign out_snap_app_limited     = o_snal_r;

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> st_r == ST_DIV) else $error("divider busy outside divide state");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !q_ready) else $error("dequeue while dividing");
  a_div_done_st: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == ST_DIV) else $error("stray divider result");

endmodule

### sv/delivery_rate_sampler.sv
// ----------------------------------------------------------------------------
// delivery_rate_sampler
// Congestion-control delivery-rate sampler: sent, acked, generate, check.
// ----------------------------------------------------------------------------
// Each operation yields one result beat. Sent, acked, check and generate
// operations that are rejected or have a zero interval are handled directly
// in the back end; a generate that computes a rate first runs the
// one-bit-per-cycle 64-bit serial divider. A two-entry queue sits in front,
// and out_last_rate reflects the rate at the time the beat is presented.
// ----------------------------------------------------------------------------
module delivery_rate_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [47:0] in_now,
  input  logic [31:0] in_bytes_in_flight,
  input  logic [31:0] in_cwnd,
  input  logic        in_nothing_pending,
  input  logic [47:0] in_min_rtt,
  input  logic [15:0] in_packet_size,
  input  logic [63:0] in_pkt_delivered,
  input  logic [47:0] in_pkt_delivered_time,
  input  logic [47:0] in_pkt_first_sent_time,
  input  logic [47:0] in_pkt_sent_time,
  input  logic        in_pkt_app_limited,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sample_valid,
  output logic [63:0] out_sample_delivered,
  output logic [47:0] out_sample_interval,
  output logic [63:0] out_last_rate,
  output logic        out_sample_app_limited,
  output logic [63:0] out_total_delivered,
  output logic [63:0] out_snap_delivered,
  output logic [47:0] out_snap_delivered_time,
  output logic [47:0] out_snap_first_sent_time,
  output logic        out_snap_app_limited
);
  import drs_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  drs_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_op                  (in_op),
    .in_now                 (in_now),
    .in_bytes_in_flight     (in_bytes_in_flight),
    .in_cwnd                (in_cwnd),
    .in_nothing_pending     (in_nothing_pending),
    .in_min_rtt             (in_min_rtt),
    .in_packet_size         (in_packet_size),
    .in_pkt_delivered       (in_pkt_delivered),
    .in_pkt_delivered_time  (in_pkt_delivered_time),
    .in_pkt_first_sent_time (in_pkt_first_sent_time),
    .in_pkt_sent_time       (in_pkt_sent_time),
    .in_pkt_app_limited     (in_pkt_app_limited),
    .q_valid                (q_valid),
    .q_ready                (q_ready),
    .q_cmd                  (q_cmd)
  );

  drs_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_valid                  (q_valid),
    .q_ready                  (q_ready),
    .q_cmd                    (q_cmd),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_sample_valid         (out_sample_valid),
    .out_sample_delivered     (out_sample_delivered),
    .out_sample_interval      (out_sample_interval),
    .out_last_rate            (out_last_rate),
    .out_sample_app_limited   (out_sample_app_limited),
    .out_total_delivered      (out_total_delivered),
    .out_snap_delivered       (out_snap_delivered),
    .out_snap_delivered_time  (out_snap_delivered_time),
    .out_snap_first_sent_time (out_snap_first_sent_time),
    .out_snap_app_limited     (out_snap_app_limited)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the delivery rate sampler. Sent, acked, generate and check
// beats are driven through a valid/ready port. A scoreboard predicts each
// result beat and compares every result field with the oldest prediction.
// Phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drs_pkg::*;

  typedef struct {
    op_t         op;
    logic [47:0] now;
    logic [31:0] bif;
    logic [31:0] cwnd;
    logic        idle;
    logic [47:0] mrtt;
    logic [15:0] psize;
    logic [63:0] pdel;
    logic [47:0] pdtime;
    logic [47:0] pfirst;
    logic [47:0] psent;
    logic        papp;
  } beat_t;

  typedef struct {
    logic        sv;
    logic [63:0] sdel;
    logic [47:0] sint;
    logic [63:0] rate;
    logic        sapp;
    logic [63:0] total;
    logic [63:0] snd;
    logic [47:0] sndt;
    logic [47:0] snft;
    logic        snapp;
  } rate_res_t;

  class rate_scoreboard;
    logic [63:0] delivered;
    logic [47:0] dstamp;
    logic [47:0] fstamp;
    logic [63:0] app_mark;
    logic [63:0] newest_del;
    logic [47:0] newest_stamp;
    logic        newest_app;
    logic [47:0] send_span;
    logic [47:0] ack_span;
    logic [63:0] rate;
    rate_res_t   pending[$];
    int          errors;

    function void clear();
      delivered = 0; dstamp = 0; fstamp = 0; app_mark = 0; newest_del = 0;
      newest_stamp = 0; newest_app = 0; send_span = 0; ack_span = 0; rate = 0;
      errors = 0;
    endfunction

    function void note(beat_t b);
      rate_res_t   r;
      logic [47:0] iv;
      logic [63:0] dl;
      logic [63:0] m;
      r = '{default: '0};
      case (b.op)
        OP_SENT: begin
          if (b.bif == 0) begin
            dstamp = b.now;
            fstamp = b.now;
          end
          r.snd = delivered;
          r.sndt = dstamp;
          r.snft = fstamp;
          r.snapp = (app_mark != 0);
        end
        OP_ACKED: begin
          if (b.pdtime != 0) begin
            delivered = delivered + 64'(b.psize);
            dstamp = b.now;
            if (b.pdel > newest_del) begin
              newest_del = b.pdel;
              newest_stamp = b.pdtime;
              newest_app = b.papp;
              send_span = b.psent - b.pfirst;
              ack_span = b.now - b.pdtime;
              fstamp = b.psent;
            end
          end
        end
        OP_GEN: begin
          if (app_mark != 0 && delivered > app_mark) app_mark = 0;
          if (newest_stamp != 0) begin
            iv = (ack_span > send_span) ? ack_span : send_span;
            dl = delivered - newest_del;
            r.sdel = dl;
            if (iv >= b.mrtt) begin
              if (iv != 0) rate = dl / 64'(iv);
              r.sv = 1;
              r.sint = iv;
            end
          end
        end
        default: begin
          if (b.bif < b.cwnd && b.idle) begin
            m = delivered + 64'(b.bif);
            app_mark = (m != 0) ? m : 64'd1;
          end
        end
      endcase
      r.rate = rate;
      r.sapp = newest_app;
      r.total = delivered;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(rate_res_t g);
      rate_res_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (g.sv !== e.sv) report("sample_valid", 64'(g.sv), 64'(e.sv));
      if (g.sdel !== e.sdel) report("sample_delivered", g.sdel, e.sdel);
      if (g.sint !== e.sint) report("sample_interval", 64'(g.sint), 64'(e.sint));
      if (g.rate !== e.rate) report("last_rate", g.rate, e.rate);
      if (g.sapp !== e.sapp) report("sample_app_limited", 64'(g.sapp), 64'(e.sapp));
      if (g.total !== e.total) report("total_delivered", g.total, e.total);
      if (g.snd !== e.snd) report("snap_delivered", g.snd, e.snd);
      if (g.sndt !== e.sndt) report("snap_delivered_time", 64'(g.sndt), 64'(e.sndt));
      if (g.snft !== e.snft) report("snap_first_sent_time", 64'(g.snft), 64'(e.snft));
      if (g.snapp !== e.snapp) report("snap_app_limited", 64'(g.snapp), 64'(e.snapp));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_op;
  logic [47:0] in_now, in_min_rtt, in_pkt_delivered_time, in_pkt_first_sent_time;
  logic [47:0] in_pkt_sent_time;
  logic [31:0] in_bytes_in_flight, in_cwnd;
  logic        in_nothing_pending, in_pkt_app_limited;
  logic [15:0] in_packet_size;
  logic [63:0] in_pkt_delivered;
  logic        out_valid, out_ready;
  logic        out_sample_valid, out_sample_app_limited, out_snap_app_limited;
  logic [63:0] out_sample_delivered, out_last_rate, out_total_delivered;
  logic [63:0] out_snap_delivered;
  logic [47:0] out_sample_interval, out_snap_delivered_time, out_snap_first_sent_time;

  rate_scoreboard sb = new();
  int          gap_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;
  logic [47:0] clock_us = 48'd1000;

  delivery_rate_sampler uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    beat_t b;
    rate_res_t g;
    if (rst_n && in_valid && in_ready) begin
      b.op = op_t'(in_op); b.now = in_now; b.bif = in_bytes_in_flight;
      b.cwnd = in_cwnd; b.idle = in_nothing_pending; b.mrtt = in_min_rtt;
      b.psize = in_packet_size; b.pdel = in_pkt_delivered;
      b.pdtime = in_pkt_delivered_time; b.pfirst = in_pkt_first_sent_time;
      b.psent = in_pkt_sent_time; b.papp = in_pkt_app_limited;
      sb.note(b);
    end
    if (rst_n && out_valid && out_ready) begin
      g.sv = out_sample_valid; g.sdel = out_sample_delivered;
      g.sint = out_sample_interval; g.rate = out_last_rate;
      g.sapp = out_sample_app_limited; g.total = out_total_delivered;
      g.snd = out_snap_delivered; g.sndt = out_snap_delivered_time;
      g.snft = out_snap_first_sent_time; g.snapp = out_snap_app_limited;
      sb.check(g);
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic beat_t blank(op_t op);
    beat_t b;
    b = '{op: op, default: '0};
    return b;
  endfunction

  task automatic drive(beat_t b);
    in_valid <= 1;
    in_op <= b.op; in_now <= b.now; in_bytes_in_flight <= b.bif;
    in_cwnd <= b.cwnd; in_nothing_pending <= b.idle; in_min_rtt <= b.mrtt;
    in_packet_size <= b.psize; in_pkt_delivered <= b.pdel;
    in_pkt_delivered_time <= b.pdtime; in_pkt_first_sent_time <= b.pfirst;
    in_pkt_sent_time <= b.psent; in_pkt_app_limited <= b.papp;
    @(posedge clk iff (in_valid && in_ready));
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic beat_t noise_beat();
    beat_t b;
    b.op = op_t'($urandom_range(3));
    b.now = 48'(rnd64()); b.bif = $urandom; b.cwnd = $urandom;
    b.idle = 1'($urandom); b.mrtt = 48'(rnd64()); b.psize = 16'($urandom);
    b.pdel = rnd64(); b.pdtime = 48'(rnd64()); b.pfirst = 48'(rnd64());
    b.psent = 48'(rnd64()); b.papp = 1'($urandom);
    return b;
  endfunction

  // well-formed traffic on an advancing clock
  function automatic beat_t flow_beat();
    beat_t b;
    b = blank(op_t'($urandom_range(3)));
    clock_us = clock_us + 48'($urandom_range(1, 300));
    b.now = clock_us;
    b.bif = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(0, 200000));
    b.cwnd = 32'($urandom_range(0, 200000));
    b.idle = 1'($urandom);
    b.mrtt = ($urandom_range(4) == 0) ? 48'd0 : 48'($urandom_range(0, 600));
    b.psize = 16'($urandom);
    b.pdel = sb.newest_del + 64'($urandom_range(0, 3000)) - 64'($urandom_range(0, 300));
    b.pdtime = ($urandom_range(9) == 0) ? 48'd0 : clock_us - 48'($urandom_range(0, 900));
    b.psent = clock_us - 48'($urandom_range(0, 900));
    b.pfirst = b.psent - 48'($urandom_range(0, 900));
    b.papp = 1'($urandom);
    return b;
  endfunction

  task automatic run_phase(int gp, int sp, int n);
    gap_pct = gp;
    stall_pct = sp;
    repeat (n) drive(($urandom_range(99) < 80) ? flow_beat() : noise_beat());
  endtask

  initial begin
    beat_t b;
    sb.clear();
    rst_n <= 0;
    in_valid <= 0;
    in_op <= OP_SENT; in_now <= 0; in_bytes_in_flight <= 0; in_cwnd <= 0;
    in_nothing_pending <= 0; in_min_rtt <= 0; in_packet_size <= 0;
    in_pkt_delivered <= 0; in_pkt_delivered_time <= 0;
    in_pkt_first_sent_time <= 0; in_pkt_sent_time <= 0; in_pkt_app_limited <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // nothing delivered yet
    drive(blank(OP_GEN));
    b = blank(OP_SENT); b.now = '1; drive(b);
    b = blank(OP_SENT); b.now = 48'd500; b.bif = '1; drive(b);
    // check with zero delivered and zero in flight stores a mark of one
    b = blank(OP_CHECK); b.cwnd = 1; b.idle = 1; drive(b);
    drive(blank(OP_SENT));
    b = blank(OP_CHECK); b.cwnd = '1; b.bif = 5; b.idle = 0; drive(b);
    // already acked
    b = blank(OP_ACKED); b.psize = '1; b.pdel = 5; drive(b);
    // zero interval with zero min rtt
    b = blank(OP_ACKED); b.now = 48'd700; b.pdtime = 48'd700; b.psent = 48'd600;
    b.pfirst = 48'd600; b.psize = 100; b.pdel = 1; b.papp = 1; drive(b);
    drive(blank(OP_GEN));
    // rejected interval
    b = blank(OP_ACKED); b.now = 48'd2000; b.pdtime = 48'd1000; b.psent = 48'd1500;
    b.pfirst = 48'd900; b.psize = '1; b.pdel = 2; drive(b);
    b = blank(OP_GEN); b.mrtt = '1; drive(b);
    b = blank(OP_GEN); b.mrtt = 48'd10; drive(b);
    b = blank(OP_CHECK); b.cwnd = '1; b.bif = '1 - 1; b.idle = 1; drive(b);
    b = blank(OP_ACKED); b.now = '1; b.pdtime = '1; b.psent = 0; b.pfirst = '1;
    b.psize = '1; b.pdel = '1; b.papp = 1; drive(b);
    drive(blank(OP_GEN));
    b = blank(OP_SENT); b.bif = 1; drive(b);

    run_phase(0, 0, 160);
    run_phase(45, 0, 160);
    run_phase(0, 45, 160);
    run_phase(36, 36, 160);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
